@@ rtl/qedsc_pkg.sv @@
// Shared types and constants for the quote escape depth scanner.
package qedsc_pkg;

	// counter width for the current and longest quote runs
	localparam int unsigned COUNT_WIDTH = 16;
	localparam int unsigned DEPTH_WIDTH = 16;
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	// wide enough to hold either counter plus one
	localparam int unsigned SUM_WIDTH =
		((COUNT_WIDTH > DEPTH_WIDTH) ? COUNT_WIDTH : DEPTH_WIDTH) + 1;

	// character codes
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_EQUALS = 8'h3d;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// fixed depths of the result
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_PLAIN   = DEPTH_WIDTH'(1);
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_QUOTED  = DEPTH_WIDTH'(3);
	localparam logic [COUNT_WIDTH-1:0] RUN_THRESHOLD = COUNT_WIDTH'(3);

	// queue between front and back
	localparam int unsigned CQ_DEPTH = 4;
	localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// result queue
	localparam int unsigned RQ_DEPTH = 2;
	localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_byte;
		logic       last_byte;
		logic       attr_mark;
	} in_beat_t;

	typedef struct packed {
		logic [DEPTH_WIDTH-1:0] quote_depth;
		logic                   start_needs_newline;
		logic                   end_needs_newline;
	} out_beat_t;

	// classified byte as carried from front to back
	typedef struct packed {
		logic is_quote;
		logic is_slash;
		logic slash_or_star;
		logic is_special;
		logic first;
		logic last;
		logic attr;
	} class_t;

endpackage

@@ rtl/quote_escape_depth_scanner_unit.sv @@
// Top level of the quote escape depth scanner: front, back and checks.
//
// Input channel: one text byte per beat, with first/last markers and the
// attribute flag; a beat is taken when push is high and full is low.
// Result channel: one beat per value, at its last byte; the oldest result
// is shown while empty is low and is taken when pop is high.
// An accepted byte is written into the byte queue and scanned from its head;
// a last byte's result is written into the result queue and empty goes low.
// Throughput: one byte per cycle while the result queue has room, set by the
// back-end state update (increment, compare, depth add on the run counters).
// A four-beat queue parts front from back and a two-beat result queue
// parts the back end from the receiver; while the receiver stalls, bytes
// of a value keep flowing until the result queue fills, then the byte
// queue fills and full rises.
// Reset clears both queues and the scan state; no clearing pass is needed.
// Values are framed by first_byte; a byte without it extends the current
// scan state as it stands.
module quote_escape_depth_scanner_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  qedsc_pkg::in_beat_t  item,
	output logic                 empty,
	input  logic                 pop,
	output qedsc_pkg::out_beat_t result
);

	logic              cq_valid;
	logic              cq_pop;
	qedsc_pkg::class_t cq_beat;

	// byte classification and queue
	qedsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cq_valid (cq_valid),
		.cq_beat  (cq_beat),
		.cq_pop   (cq_pop)
	);

	// scan state and results
	qedsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_beat  (cq_beat),
		.cq_pop   (cq_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// an accepted byte is in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> cq_valid)
		else $error("accepted byte missing from queue");

	// the back end never takes from an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> cq_valid)
		else $error("back end popped an empty queue");

	// a scanned last byte always leaves a result waiting
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop && cq_beat.last |=> !empty)
		else $error("last byte gave no result");

endmodule

@@ rtl/qedsc_front.sv @@
// Front end: classifies each accepted byte and queues the classes for the back end.
module qedsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  qedsc_pkg::in_beat_t item,
	output logic               cq_valid,
	output qedsc_pkg::class_t  cq_beat,
	input  logic               cq_pop
);

	qedsc_pkg::class_t cls;
	qedsc_pkg::class_t cq_mem_q [qedsc_pkg::CQ_DEPTH];
	logic [qedsc_pkg::CQ_PTR_W-1:0] wr_ptr_q;
	logic [qedsc_pkg::CQ_PTR_W-1:0] rd_ptr_q;
	logic [qedsc_pkg::CQ_CNT_W-1:0] count_q;
	logic wr_en;
	logic rd_en;

	// byte classification
	always_comb begin
		cls.is_quote      = (item.text_byte == qedsc_pkg::CH_QUOTE);
		cls.is_slash      = (item.text_byte == qedsc_pkg::CH_SLASH);
		cls.slash_or_star = (item.text_byte == qedsc_pkg::CH_SLASH) ||
			(item.text_byte == qedsc_pkg::CH_STAR);
		cls.is_special    = (item.text_byte == qedsc_pkg::CH_EQUALS) ||
			(item.text_byte == qedsc_pkg::CH_LPAREN) ||
			(item.text_byte == qedsc_pkg::CH_RPAREN) ||
			(item.text_byte == qedsc_pkg::CH_LBRACE) ||
			(item.text_byte == qedsc_pkg::CH_RBRACE) ||
			(item.text_byte == qedsc_pkg::CH_SPACE) ||
			(item.text_byte == qedsc_pkg::CH_LF) ||
			(item.text_byte == qedsc_pkg::CH_CR) ||
			(item.text_byte == qedsc_pkg::CH_TAB);
		cls.first         = item.first_byte;
		cls.last          = item.last_byte;
		cls.attr          = item.attr_mark;
	end

	// queue control
	assign full     = (count_q == qedsc_pkg::CQ_CNT_W'(qedsc_pkg::CQ_DEPTH));
	assign cq_valid = (count_q != '0);
	assign wr_en    = push && !full;
	assign rd_en    = cq_pop && cq_valid;
	assign cq_beat  = cq_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	// queue storage, no reset
	always_ff @(posedge clk) begin
		if (wr_en) cq_mem_q[wr_ptr_q] <= cls;
	end

endmodule

@@ rtl/qedsc_back.sv @@
// Back end: per-value scan state, depth calculation and result queue.
module qedsc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cq_valid,
	input  qedsc_pkg::class_t    cq_beat,
	output logic                 cq_pop,
	output logic                 empty,
	input  logic                 pop,
	output qedsc_pkg::out_beat_t result
);

	logic [qedsc_pkg::COUNT_WIDTH-1:0] run_q, longest_q;
	logic esc_q, saw_q, began_quote_q, began_slash_q, at_second_q;

	logic [qedsc_pkg::COUNT_WIDTH-1:0] run_b, long_b, run_n, long_n;
	logic esc_n, saw_n, began_quote_n, began_slash_n, at_second_n;
	logic [qedsc_pkg::SUM_WIDTH-1:0] long_ext;
	logic [qedsc_pkg::DEPTH_WIDTH-1:0] depth;
	qedsc_pkg::out_beat_t res;

	qedsc_pkg::out_beat_t rq_mem_q [qedsc_pkg::RQ_DEPTH];
	logic [qedsc_pkg::RQ_PTR_W-1:0] rq_wr_q, rq_rd_q;
	logic [qedsc_pkg::RQ_CNT_W-1:0] rq_count_q;
	logic rq_full, rq_wr, rq_rd;

	// consume a class beat whenever the result queue has room
	assign rq_full = (rq_count_q == qedsc_pkg::RQ_CNT_W'(qedsc_pkg::RQ_DEPTH));
	assign cq_pop  = cq_valid && !rq_full;

	// next scan state for the beat at the head of the queue
	always_comb begin
		run_b         = cq_beat.first ? '0 : run_q;
		long_b        = cq_beat.first ? '0 : longest_q;
		saw_n         = cq_beat.first ? 1'b0 : saw_q;
		esc_n         = cq_beat.first ? 1'b0 :
			(esc_q || (at_second_q && began_slash_q && cq_beat.slash_or_star));
		began_quote_n = cq_beat.first ? cq_beat.is_quote : began_quote_q;
		began_slash_n = cq_beat.first ? cq_beat.is_slash : began_slash_q;
		at_second_n   = cq_beat.first;
		if (cq_beat.is_quote) begin
			run_n  = (run_b == qedsc_pkg::COUNT_MAX) ? run_b : run_b + 1'b1;
			long_n = (run_n > long_b) ? run_n : long_b;
			esc_n  = 1'b1;
			saw_n  = 1'b1;
		end else begin
			run_n  = '0;
			long_n = long_b;
			if (cq_beat.is_special) esc_n = 1'b1;
		end
		if (cq_beat.attr) esc_n = 1'b1;
	end

	// quoting depth from the sticky flags and the longest run
	always_comb begin
		long_ext = qedsc_pkg::SUM_WIDTH'(long_n);
		if (!esc_n)
			depth = '0;
		else if (!saw_n)
			depth = qedsc_pkg::DEPTH_PLAIN;
		else if (long_n < qedsc_pkg::RUN_THRESHOLD)
			depth = qedsc_pkg::DEPTH_QUOTED;
		else if (long_ext >= qedsc_pkg::SUM_WIDTH'(qedsc_pkg::DEPTH_MAX))
			depth = qedsc_pkg::DEPTH_MAX;
		else
			depth = qedsc_pkg::DEPTH_WIDTH'(long_ext + 1'b1);
		res.quote_depth         = depth;
		res.start_needs_newline = began_quote_n;
		res.end_needs_newline   = cq_beat.is_quote;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= '0;
			longest_q     <= '0;
			esc_q         <= 1'b0;
			saw_q         <= 1'b0;
			began_quote_q <= 1'b0;
			began_slash_q <= 1'b0;
			at_second_q   <= 1'b0;
		end else if (cq_pop) begin
			run_q         <= run_n;
			longest_q     <= long_n;
			esc_q         <= esc_n;
			saw_q         <= saw_n;
			began_quote_q <= began_quote_n;
			began_slash_q <= began_slash_n;
			at_second_q   <= at_second_n;
		end
	end

	// result queue
	assign rq_wr  = cq_pop && cq_beat.last;
	assign rq_rd  = pop && !empty;
	assign empty  = (rq_count_q == '0);
	assign result = rq_mem_q[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q    <= '0;
			rq_rd_q    <= '0;
			rq_count_q <= '0;
		end else begin
			if (rq_wr) rq_wr_q <= rq_wr_q + 1'b1;
			if (rq_rd) rq_rd_q <= rq_rd_q + 1'b1;
			if (rq_wr && !rq_rd)
				rq_count_q <= rq_count_q + 1'b1;
			else if (rq_rd && !rq_wr)
				rq_count_q <= rq_count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rq_wr) rq_mem_q[rq_wr_q] <= res;
	end

endmodule

@@ sim/quote_escape_depth_scanner_unit_tb.sv @@
// Self-checking testbench for the quote escape depth scanner unit.
module quote_escape_depth_scanner_unit_tb;

	typedef logic [7:0] text_q_t[$];
	typedef logic [qedsc_pkg::COUNT_WIDTH-1:0] run_t;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned RANDOM_BYTES = 800;
	localparam int unsigned LONG_RUN = 20;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam logic [7:0] SPECIALS [9] = '{qedsc_pkg::CH_EQUALS, qedsc_pkg::CH_LPAREN,
		qedsc_pkg::CH_RPAREN, qedsc_pkg::CH_LBRACE, qedsc_pkg::CH_RBRACE,
		qedsc_pkg::CH_SPACE, qedsc_pkg::CH_LF, qedsc_pkg::CH_CR, qedsc_pkg::CH_TAB};
	localparam logic [7:0] CH_LETTER_A = 8'h61;

	// Tracks the scan state of the value in flight and the depths still owed
	class quote_depth_board;
		run_t                 run_len;
		run_t                 best_run;
		bit                   escape;
		bit                   any_quote;
		bit                   lead_quote;
		bit                   lead_slash;
		bit                   second_next;
		qedsc_pkg::out_beat_t owed_depths[$];
		int unsigned          error_count;

		function void take_byte(qedsc_pkg::in_beat_t b);
			logic [7:0]           c;
			qedsc_pkg::out_beat_t r;
			c = b.text_byte;
			// first byte restarts the value
			if (b.first_byte) begin
				run_len     = '0;
				best_run    = '0;
				escape      = 1'b0;
				any_quote   = 1'b0;
				lead_quote  = (c == qedsc_pkg::CH_QUOTE);
				lead_slash  = (c == qedsc_pkg::CH_SLASH);
				second_next = 1'b1;
			end else if (second_next) begin
				// comment prefix needs the second byte
				if (lead_slash && (c == qedsc_pkg::CH_SLASH || c == qedsc_pkg::CH_STAR))
					escape = 1'b1;
				second_next = 1'b0;
			end
			if (c == qedsc_pkg::CH_QUOTE) begin
				escape    = 1'b1;
				any_quote = 1'b1;
				if (run_len != qedsc_pkg::COUNT_MAX)
					run_len++;
				if (run_len > best_run)
					best_run = run_len;
			end else begin
				run_len = '0;
				if (c inside {SPECIALS})
					escape = 1'b1;
			end
			if (b.attr_mark)
				escape = 1'b1;
			if (!b.last_byte)
				return;
			// depth at the last byte
			if (!escape)
				r.quote_depth = '0;
			else if (!any_quote)
				r.quote_depth = qedsc_pkg::DEPTH_PLAIN;
			else if (best_run < qedsc_pkg::RUN_THRESHOLD)
				r.quote_depth = qedsc_pkg::DEPTH_QUOTED;
			else if (64'(best_run) >= 64'(qedsc_pkg::DEPTH_MAX))
				r.quote_depth = qedsc_pkg::DEPTH_MAX;
			else
				r.quote_depth = qedsc_pkg::DEPTH_WIDTH'(64'(best_run) + 1);
			r.start_needs_newline = lead_quote;
			r.end_needs_newline   = (c == qedsc_pkg::CH_QUOTE);
			owed_depths = {owed_depths, r};
		endfunction

		function void check_result(qedsc_pkg::out_beat_t got);
			qedsc_pkg::out_beat_t want;
			if (owed_depths.size() == 0) begin
				$error("unexpected result beat: %p", got);
				error_count++;
				return;
			end
			want = owed_depths.pop_front();
			if (got.quote_depth !== want.quote_depth) begin
				$error("quote_depth: expected %0d, got %0d", want.quote_depth,
					got.quote_depth);
				error_count++;
			end
			if (got.start_needs_newline !== want.start_needs_newline) begin
				$error("start_needs_newline: expected %0b, got %0b",
					want.start_needs_newline, got.start_needs_newline);
				error_count++;
			end
			if (got.end_needs_newline !== want.end_needs_newline) begin
				$error("end_needs_newline: expected %0b, got %0b",
					want.end_needs_newline, got.end_needs_newline);
				error_count++;
			end
		endfunction

		function int unsigned owed();
			return owed_depths.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	qedsc_pkg::in_beat_t  item;
	logic                 empty;
	logic                 pop;
	qedsc_pkg::out_beat_t result;

	quote_depth_board board = new();
	int unsigned      bytes_sent;
	int unsigned      cycles;
	bit               hold_req;

	quote_escape_depth_scanner_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one beat until taken, then idle for a while unless steady
	task automatic send_beat(qedsc_pkg::in_beat_t b, bit steady);
		int unsigned gap;
		@(negedge clk);
		push <= 1'b1;
		item <= b;
		do
			@(posedge clk);
		while (full);
		board.take_byte(b);
		bytes_sent++;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			@(negedge clk);
			push <= 1'b0;
			item <= qedsc_pkg::in_beat_t'($bits(qedsc_pkg::in_beat_t)'($urandom));
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// one value, framed as asked, attribute set on attr_pct percent of bytes
	task automatic send_text(text_q_t t, bit mark_first, bit mark_last, bit scramble,
			int unsigned attr_pct, bit steady);
		qedsc_pkg::in_beat_t b;
		foreach (t[i]) begin
			b.text_byte  = t[i];
			b.first_byte = scramble ? 1'($urandom) : (mark_first && i == 0);
			b.last_byte  = scramble ? 1'($urandom) : (mark_last && i == t.size() - 1);
			b.attr_mark  = ($urandom_range(1, 100) <= attr_pct);
			send_beat(b, steady);
		end
	endtask

	// random value with quote runs, specials and comment prefixes mixed in
	function automatic text_q_t random_text();
		text_q_t     t;
		int unsigned n;
		int unsigned k;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
		if ($urandom_range(0, 5) == 0)
			t = {t, qedsc_pkg::CH_SLASH};
		while (t.size() < n) begin
			k = $urandom_range(0, 99);
			if (k < 30)
				repeat ($urandom_range(1, 5)) t = {t, qedsc_pkg::CH_QUOTE};
			else if (k < 45)
				t = {t, SPECIALS[$urandom_range(0, 8)]};
			else if (k < 55)
				t = {t, $urandom_range(0, 1) ? qedsc_pkg::CH_SLASH : qedsc_pkg::CH_STAR};
			else
				t = {t, 8'($urandom_range(0, 255))};
		end
		return t;
	endfunction

	// receiver: random pops, steady stretches, one long hold-off on request
	initial begin
		int unsigned gap;
		bit          rx_steady;
		pop = 1'b0;
		rx_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			gap = rx_steady ? 0 : idle_len();
			if (gap != 0) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			board.check_result(result);
		end
	end

	// stimulus
	initial begin
		qedsc_pkg::in_beat_t b;
		int unsigned         m;
		bit                  steady;
		arst_n     = 1'b0;
		push       = 1'b0;
		item       = '0;
		hold_req   = 1'b0;
		bytes_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: lone slash, both comment prefixes, slashes past the start
		send_text('{qedsc_pkg::CH_SLASH}, 1, 1, 0, 0, 0);
		send_text('{qedsc_pkg::CH_SLASH, qedsc_pkg::CH_SLASH}, 1, 1, 0, 0, 0);
		send_text('{qedsc_pkg::CH_SLASH, qedsc_pkg::CH_STAR}, 1, 1, 0, 0, 1);
		send_text('{CH_LETTER_A, qedsc_pkg::CH_SLASH, qedsc_pkg::CH_SLASH}, 1, 1, 0, 0, 0);
		// lone quote, attribute only, byte extremes
		send_text('{qedsc_pkg::CH_QUOTE}, 1, 1, 0, 0, 0);
		send_text('{8'hff}, 1, 1, 0, 100, 0);
		send_text('{8'h00}, 1, 1, 0, 0, 1);
		// run of three, then a longer run kept over a shorter later one
		send_text('{qedsc_pkg::CH_QUOTE, qedsc_pkg::CH_QUOTE, qedsc_pkg::CH_QUOTE},
			1, 1, 0, 0, 0);
		send_text('{qedsc_pkg::CH_QUOTE, qedsc_pkg::CH_QUOTE, qedsc_pkg::CH_QUOTE,
			qedsc_pkg::CH_QUOTE, CH_LETTER_A, qedsc_pkg::CH_QUOTE}, 1, 1, 0, 0, 0);
		// byte with no first marker continues the last value
		send_text('{CH_LETTER_A}, 0, 1, 0, 0, 0);

		// one long quote run, back to back
		for (int unsigned i = 0; i < LONG_RUN; i++) begin
			b.text_byte  = qedsc_pkg::CH_QUOTE;
			b.first_byte = (i == 0);
			b.last_byte  = (i == LONG_RUN - 1);
			b.attr_mark  = 1'b0;
			send_beat(b, 1);
		end

		// random values; receiver holds off at the start so the block backs up
		hold_req = 1'b1;
		while (bytes_sent < RANDOM_BYTES) begin
			m = $urandom_range(0, 99);
			steady = (hold_req || $urandom_range(0, 4) == 0);
			if (m < 85)
				send_text(random_text(), 1, 1, 0,
					($urandom_range(0, 7) == 0) ? 50 : 0, steady);
			else if (m < 91)
				send_text(random_text(), 0, 1, 0, 0, steady);
			else if (m < 96)
				send_text(random_text(), 1, 0, 0, 5, steady);
			else
				send_text(random_text(), 0, 0, 1, 10, steady);
		end
		@(negedge clk);
		push <= 1'b0;

		// drain, then allow for a stray late beat
		while (board.owed() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
